// ----- src/pffl_pkg.sv -----
`default_nettype none
package pffl_pkg;

    // item kinds carried on the kind port
    typedef enum logic [2:0] {
        KIND_CLEAR   = 3'd0,
        KIND_RESERVE = 3'd1,
        KIND_ADD_RAM = 3'd2,
        KIND_ALLOC   = 3'd3,
        KIND_FREE    = 3'd4
    } kind_t;

    // widths of the fixed result fields
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 11;

endpackage
`default_nettype wire

// ----- src/pffl_range.sv -----
`default_nettype none
// Turns a byte range into a frame walk [first, stop).
// Reserve rounds outward, add-RAM rounds inward; stop is clamped to the map.
module pffl_range #(
    parameter int FRAME_COUNT = 1024,
    parameter int PAGE_BYTES  = 4096,
    parameter int WW          = 21
) (
    input  wire logic [2:0]              kind,
    input  wire logic [31:0]             region_start,
    input  wire logic [31:0]             region_end,
    output logic      [WW-1:0]           first,
    output logic      [WW-1:0]           stop
);
    import pffl_pkg::*;

    localparam int          PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [32:0] RoundAdd   = 33'(PAGE_BYTES - 1);

    logic          is_rsv;
    logic [32:0]   lo_sum;
    logic [32:0]   hi_sum;
    logic [WW-1:0] stop_raw;

    // round start up for RAM, round end up for reserve
    always_comb
    begin
        is_rsv   = (kind_t'(kind) == KIND_RESERVE);
        lo_sum   = {1'b0, region_start} + (is_rsv ? 33'd0 : RoundAdd);
        hi_sum   = {1'b0, region_end} + (is_rsv ? RoundAdd : 33'd0);
        first    = WW'(lo_sum >> PAGE_SHIFT);
        stop_raw = WW'(hi_sum >> PAGE_SHIFT);
        stop     = (stop_raw > WW'(FRAME_COUNT)) ? WW'(FRAME_COUNT) : stop_raw;
    end

endmodule
`default_nettype wire

// ----- src/page_frame_free_list_allocator.sv -----
`default_nettype none
// Clear, allocate, free and unused kinds report their result in the cycle after acceptance;
//   reserve and add-RAM report once their N frames are walked, one frame per cycle.
// Busy stays high after accept for allocate with more than one frame listed
//   (link memory read), clear (reserved map swept) and range items (frame walk).
// Reset: busy while the reserved map is swept to zero.
// The receiver cannot stall; results are presented for a single cycle.
module page_frame_free_list_allocator #(
    parameter int FRAME_COUNT = 1024,
    parameter int PAGE_BYTES  = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] region_start,
    input  wire logic [31:0] region_end,
    input  wire logic [31:0] page_address,
    output logic             busy,
    output logic             done,
    output logic [pffl_pkg::ADDR_W-1:0]  frame_address,
    output logic             out_of_memory,
    output logic [pffl_pkg::COUNT_W-1:0] free_count,
    output logic [pffl_pkg::COUNT_W-1:0] usable_pages
);
    import pffl_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int FW         = $clog2(FRAME_COUNT);
    localparam int CW         = $clog2(FRAME_COUNT + 1);
    localparam int SW         = 33 - PAGE_SHIFT;
    localparam int WW         = (SW > CW) ? SW : CW;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SWEEP = 5'b00010,
        ST_RSV   = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_POP   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [FW-1:0]   sweep_reg, sweep_next;
    logic [WW-1:0]   walk_reg, walk_next;
    logic [WW-1:0]   stop_reg, stop_next;
    logic            pipe_valid_reg, pipe_valid_next;
    logic [FW-1:0]   pipe_frame_reg, pipe_frame_next;
    logic [FW-1:0]   head_reg, head_next;
    logic [FW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   usable_reg, usable_next;
    logic            done_reg, done_next;
    logic [31:0]     addr_reg, addr_next;
    logic            oom_reg, oom_next;

    // memories
    logic [FW-1:0]   link_mem [FRAME_COUNT];
    logic            mark_mem [FRAME_COUNT];
    logic [FW-1:0]   link_rd_reg;
    logic            mark_rd_reg;
    logic            link_we;
    logic [FW-1:0]   link_waddr;
    logic [FW-1:0]   link_wdata;
    logic            mark_we;
    logic [FW-1:0]   mark_waddr;
    logic            mark_wdata;

    logic            accept;
    logic [WW-1:0]   rng_first;
    logic [WW-1:0]   rng_stop;
    logic [WW-1:0]   free_frame_w;
    logic            walk_more;
    logic [32+FW+PAGE_SHIFT-1:0] head_addr_w;
    logic [COUNT_W+CW-1:0]       free_count_w;
    logic [COUNT_W+CW-1:0]       usable_w;

    pffl_range #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BYTES  (PAGE_BYTES),
        .WW          (WW)
    ) u_range (
        .kind         (kind),
        .region_start (region_start),
        .region_end   (region_end),
        .first        (rng_first),
        .stop         (rng_stop)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign free_frame_w = WW'(page_address >> PAGE_SHIFT);
    assign walk_more    = (walk_reg < stop_reg);
    assign head_addr_w  = {{32{1'b0}}, head_reg, {PAGE_SHIFT{1'b0}}};

    // result ports
    assign free_count_w  = {{COUNT_W{1'b0}}, count_reg};
    assign usable_w      = {{COUNT_W{1'b0}}, usable_reg};
    assign done          = done_reg;
    assign frame_address = addr_reg;
    assign out_of_memory = oom_reg;
    assign free_count    = free_count_w[COUNT_W-1:0];
    assign usable_pages  = usable_w[COUNT_W-1:0];

    // control and list update
    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        walk_next       = walk_reg;
        stop_next       = stop_reg;
        pipe_valid_next = 1'b0;
        pipe_frame_next = pipe_frame_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        usable_next     = usable_reg;
        done_next       = 1'b0;
        addr_next       = addr_reg;
        oom_next        = oom_reg;
        link_we         = 1'b0;
        link_waddr      = tail_reg;
        link_wdata      = pipe_frame_reg;
        mark_we         = 1'b0;
        mark_waddr      = walk_reg[FW-1:0];
        mark_wdata      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = '0;
                    oom_next  = 1'b0;
                    unique case (kind_t'(kind))
                        KIND_CLEAR:
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            count_next  = '0;
                            usable_next = '0;
                            sweep_next  = '0;
                            state_next  = ST_SWEEP;
                            done_next   = 1'b1;
                        end
                        KIND_RESERVE:
                        begin
                            walk_next  = rng_first;
                            stop_next  = rng_stop;
                            state_next = ST_RSV;
                        end
                        KIND_ADD_RAM:
                        begin
                            walk_next  = rng_first;
                            stop_next  = rng_stop;
                            state_next = ST_ADD;
                        end
                        KIND_ALLOC:
                        begin
                            done_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                oom_next = 1'b1;
                            end
                            else
                            begin
                                addr_next  = head_addr_w[31:0];
                                count_next = count_reg - 1'b1;
                                // successor comes from the link memory next cycle
                                if (count_reg > CW'(1))
                                begin
                                    state_next = ST_POP;
                                end
                            end
                        end
                        KIND_FREE:
                        begin
                            done_next = 1'b1;
                            if ((free_frame_w < WW'(FRAME_COUNT)) &&
                                (count_reg < CW'(FRAME_COUNT)))
                            begin
                                if (count_reg == '0)
                                begin
                                    tail_next = free_frame_w[FW-1:0];
                                end
                                else
                                begin
                                    link_we    = 1'b1;
                                    link_waddr = free_frame_w[FW-1:0];
                                    link_wdata = head_reg;
                                end
                                head_next  = free_frame_w[FW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                mark_we    = 1'b1;
                mark_waddr = sweep_reg;
                mark_wdata = 1'b0;
                if (sweep_reg == FW'(FRAME_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_RSV:
            begin
                if (walk_more)
                begin
                    mark_we   = 1'b1;
                    walk_next = walk_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_ADD:
            begin
                // issue: mark read of the current frame
                if (walk_more)
                begin
                    pipe_valid_next = 1'b1;
                    pipe_frame_next = walk_reg[FW-1:0];
                    walk_next       = walk_reg + 1'b1;
                end
                // append: mark data is back for the frame issued last cycle
                if (pipe_valid_reg && !mark_rd_reg && (count_reg < CW'(FRAME_COUNT)))
                begin
                    if (count_reg == '0)
                    begin
                        head_next = pipe_frame_reg;
                    end
                    else
                    begin
                        link_we = 1'b1;
                    end
                    tail_next  = pipe_frame_reg;
                    count_next = count_reg + 1'b1;
                    if (usable_reg < CW'(FRAME_COUNT))
                    begin
                        usable_next = usable_reg + 1'b1;
                    end
                end
                if (!walk_more && !pipe_valid_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_POP:
            begin
                head_next  = link_rd_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_reg      <= '0;
            walk_reg       <= '0;
            stop_reg       <= '0;
            pipe_valid_reg <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            usable_reg     <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            walk_reg       <= walk_next;
            stop_reg       <= stop_next;
            pipe_valid_reg <= pipe_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            usable_reg     <= usable_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pipe_frame_reg <= pipe_frame_next;
        addr_reg       <= addr_next;
        oom_reg        <= oom_next;
    end

    // link memory: successor of each frame, read at the head
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd_reg <= link_mem[head_reg];
    end

    // reserved map, read at the walk position
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[walk_reg[FW-1:0]];
    end

    // checks
    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind != KIND_RESERVE && kind != KIND_ADD_RAM) |=> done_reg)
        else $error("single-step item did not report next cycle");

    a_pop_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> $past(accept && kind == KIND_ALLOC))
        else $error("pop state entered without an allocate");

    a_oom_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && oom_reg) |-> (count_reg == '0 && addr_reg == '0))
        else $error("out of memory reported with frames on the list");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CW'(FRAME_COUNT)) && (usable_reg <= CW'(FRAME_COUNT)))
        else $error("frame count beyond map size");

endmodule
`default_nettype wire
